// ===== hw/rtl/tadda_pkg.sv =====
// ----------------------------------------------------------------------------
// tadda_pkg
// Shared types and codes for the three-axis DDA step generator.
// ----------------------------------------------------------------------------
package tadda_pkg;

    localparam int NUM_AXES     = 3;
    localparam int CFG_IDX_BITS = 3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_X    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Y    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Z    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POS_DIR  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_DIR = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOMED    = 3'd5;

    // merge -> lanes
    typedef struct packed {
        logic load;     // load transfer: latch a new move
        logic tick;     // tick transfer while a move is running
        logic commit;   // pulses are real, count positions
    } t_lane_ctl;

    // lanes -> merge
    typedef struct packed {
        logic hit;      // axis pulses in this slot
        logic enabled;  // axis has a nonzero magnitude
        logic toward;   // axis moves toward its limit switch
        logic dir;      // direction level currently driven
    } t_lane_stat;

endpackage

// ===== hw/rtl/tadda_lane.sv =====
// ----------------------------------------------------------------------------
// tadda_lane
// One axis: clamp on load, DDA error accumulator per slot, position counter.
// ----------------------------------------------------------------------------
module tadda_lane
    import tadda_pkg::*;
#(
    parameter int MOVE_BITS     = 15,
    parameter int POSITION_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic signed [15:0]       i_move,
    input  logic [MOVE_BITS-1:0]     i_max_steps,
    input  logic                     i_pos_dir,
    input  logic                     i_home_dir,
    input  logic                     i_homed,
    input  logic [MOVE_BITS-1:0]     i_major,
    output t_lane_stat               o_stat,
    output logic [MOVE_BITS-1:0]     o_load_mag,
    output logic [POSITION_BITS-1:0] o_pos
);

    localparam int W = ((MOVE_BITS > 16) ? MOVE_BITS : 16) + 2;

    logic [MOVE_BITS-1:0]     r_mag;
    logic [MOVE_BITS-1:0]     r_acc;
    logic                     r_enabled;
    logic                     r_toward;
    logic                     r_dir;
    logic [POSITION_BITS-1:0] r_pos;

    logic signed [W-1:0]  req_w;
    logic signed [W-1:0]  lim_w;
    logic signed [W-1:0]  clamp_w;
    logic [W-1:0]         abs_w;
    logic [MOVE_BITS-1:0] load_mag;
    logic                 load_dir;
    logic [MOVE_BITS:0]   sum;
    logic                 ge;
    logic [MOVE_BITS:0]   n_acc_w;

    always_comb begin
        req_w = {{(W-16){i_move[15]}}, i_move};
        lim_w = {{(W-MOVE_BITS){1'b0}}, i_max_steps};
        if (req_w > lim_w) begin
            clamp_w = lim_w;
        end else if (req_w < -lim_w) begin
            clamp_w = -lim_w;
        end else begin
            clamp_w = req_w;
        end
        abs_w    = clamp_w[W-1] ? unsigned'(-clamp_w) : unsigned'(clamp_w);
        load_mag = abs_w[MOVE_BITS-1:0];
        load_dir = (!clamp_w[W-1] && (clamp_w != '0)) ? i_pos_dir : ~i_pos_dir;
    end

    always_comb begin
        sum     = {1'b0, r_acc} + {1'b0, r_mag};
        ge      = (sum >= {1'b0, i_major});
        n_acc_w = ge ? (sum - {1'b0, i_major}) : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag     <= '0;
            r_acc     <= '0;
            r_enabled <= 1'b0;
            r_toward  <= 1'b0;
            r_dir     <= 1'b0;
            r_pos     <= '0;
        end else begin
            if (i_ctl.load) begin
                r_mag     <= load_mag;
                r_acc     <= '0;
                r_enabled <= (load_mag != '0);
                r_toward  <= (load_dir == i_home_dir);
                if (load_mag != '0) begin
                    r_dir <= load_dir;
                end
            end else if (i_ctl.tick) begin
                r_acc <= n_acc_w[MOVE_BITS-1:0];
            end
            if (i_ctl.commit && ge && r_enabled && i_homed) begin
                if (r_dir == i_pos_dir) begin
                    r_pos <= r_pos + POSITION_BITS'(1);
                end else begin
                    r_pos <= r_pos - POSITION_BITS'(1);
                end
            end
        end
    end

    assign o_stat.hit     = ge && r_enabled;
    assign o_stat.enabled = r_enabled;
    assign o_stat.toward  = r_toward;
    assign o_stat.dir     = r_dir;
    assign o_load_mag     = load_mag;
    assign o_pos          = r_pos;

endmodule

// ===== hw/rtl/tadda_merge.sv =====
// ----------------------------------------------------------------------------
// tadda_merge
// Combines lane results: major count, slot counter, fault and done, handshake.
// ----------------------------------------------------------------------------
module tadda_merge
    import tadda_pkg::*;
#(
    parameter int MOVE_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic [2:0]           i_limit_before,
    input  logic [2:0]           i_limit_after,
    input  t_lane_stat           i_stat [NUM_AXES],
    input  logic [MOVE_BITS-1:0] i_load_mag [NUM_AXES],
    output t_lane_ctl            o_ctl,
    output logic [MOVE_BITS-1:0] o_major,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_step_mask,
    output logic                 o_move_done,
    output logic                 o_move_fault,
    output logic                 o_busy_res
);

    logic [MOVE_BITS-1:0] r_major;
    logic [MOVE_BITS-1:0] r_slot;
    logic                 r_active;
    logic                 r_out_valid;
    logic [2:0]           r_step;
    logic                 r_done;
    logic                 r_fault;

    logic [MOVE_BITS-1:0] n_major;
    logic [MOVE_BITS-1:0] n_slot;
    logic                 n_active;
    logic [2:0]           n_step;
    logic                 n_done;
    logic                 n_fault;

    logic                 xfer;
    logic [2:0]           hits;
    logic [2:0]           enabled;
    logic [2:0]           toward;
    logic                 fault_b;
    logic                 fault_a;
    logic [MOVE_BITS-1:0] slot_inc;
    logic [MOVE_BITS-1:0] max_xy;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign xfer       = i_in_valid && o_in_ready;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            hits[a]    = i_stat[a].hit;
            enabled[a] = i_stat[a].enabled;
            toward[a]  = i_stat[a].toward;
        end
        fault_b  = |(hits & toward & i_limit_before);
        fault_a  = |(enabled & toward & i_limit_after);
        slot_inc = r_slot + MOVE_BITS'(1);
        max_xy   = (i_load_mag[1] > i_load_mag[0]) ? i_load_mag[1] : i_load_mag[0];
    end

    always_comb begin
        o_ctl.load   = xfer && (i_req_type == REQ_LOAD);
        o_ctl.tick   = xfer && (i_req_type == REQ_TICK) && r_active;
        o_ctl.commit = o_ctl.tick && !fault_b;
    end

    always_comb begin
        n_major  = r_major;
        n_slot   = r_slot;
        n_active = r_active;
        n_step   = '0;
        n_done   = 1'b0;
        n_fault  = 1'b0;
        if (o_ctl.load) begin
            n_major  = (i_load_mag[2] > max_xy) ? i_load_mag[2] : max_xy;
            n_slot   = '0;
            n_active = (n_major != '0);
            n_done   = (n_major == '0);
        end else if (o_ctl.tick) begin
            if (fault_b) begin
                n_active = 1'b0;
                n_fault  = 1'b1;
            end else if (fault_a) begin
                n_active = 1'b0;
                n_fault  = 1'b1;
                n_step   = hits;
            end else begin
                n_slot = slot_inc;
                n_step = hits;
                if (slot_inc >= r_major) begin
                    n_active = 1'b0;
                    n_done   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major     <= '0;
            r_slot      <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_done      <= 1'b0;
            r_fault     <= 1'b0;
        end else begin
            if (xfer) begin
                r_major     <= n_major;
                r_slot      <= n_slot;
                r_active    <= n_active;
                r_out_valid <= 1'b1;
                r_step      <= n_step;
                r_done      <= n_done;
                r_fault     <= n_fault;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_major      = r_major;
    assign o_out_valid  = r_out_valid;
    assign o_step_mask  = r_step;
    assign o_move_done  = r_done;
    assign o_move_fault = r_fault;
    assign o_busy_res   = r_active;

    a_done_fault_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_done && r_fault))
        else $error("done and fault reported together");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_done || r_fault)) |-> !r_active)
        else $error("move ended but still busy");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_slot < r_major))
        else $error("slot index past major count");

    a_step_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_step != '0)) |-> (r_active || r_done || r_fault))
        else $error("pulses reported outside a move");

    a_fault_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.tick && fault_b) |=> (!r_active && r_fault))
        else $error("fault before pulse did not end the move");

endmodule

// ===== hw/rtl/three_axis_dda_step_generator_core.sv =====
// ----------------------------------------------------------------------------
// three_axis_dda_step_generator_core
// Three-axis Bresenham/DDA step generator with limit checks and positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready): req_type LOAD latches a clamped
//   X/Y/Z move, req_type TICK runs one step slot with limit samples taken
//   before and after the pulse. Every input transfer yields exactly one
//   result on the output channel (o_out_valid/i_out_ready).
//   Result: registered, valid in the cycle after the input transfer.
//   Throughput: one item per cycle unless the output stalls; the three axis
//   lanes update their error accumulators in parallel and the merge stage
//   resolves fault/done in the same cycle; the single output register is the only limit.
//   Stall: while a result waits for i_out_ready, o_in_ready is low; it is
//   high again in the cycle the waiting result is taken, so a transfer can
//   happen on both sides in the same cycle.
//   Config: plain write port (i_cfg_we/i_cfg_idx/i_cfg_data); the user must
//   write it only while no result is outstanding, unchecked by the block.
//   Reset (synchronous, i_rst_n low): idle, positions and directions zero,
//   max steps 32767, positive direction mask 7, other masks 0.
// ----------------------------------------------------------------------------
module three_axis_dda_step_generator_core
    import tadda_pkg::*;
#(
    parameter int MOVE_BITS     = 15,
    parameter int POSITION_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [MOVE_BITS-1:0]    i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_req_type,
    input  logic signed [15:0]      i_move_x,
    input  logic signed [15:0]      i_move_y,
    input  logic signed [15:0]      i_move_z,
    input  logic [2:0]              i_limit_before,
    input  logic [2:0]              i_limit_after,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [2:0]              o_step_mask,
    output logic [2:0]              o_dir_level,
    output logic                    o_move_done,
    output logic                    o_move_fault,
    output logic                    o_busy_res,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z
);

    logic [MOVE_BITS-1:0] r_max_steps [NUM_AXES];
    logic [2:0]           r_pos_dir;
    logic [2:0]           r_home_dir;
    logic [2:0]           r_homed;

    t_lane_ctl            lane_ctl;
    t_lane_stat           lane_stat [NUM_AXES];
    logic [MOVE_BITS-1:0] load_mag  [NUM_AXES];
    logic [MOVE_BITS-1:0] major;
    logic signed [15:0]   move      [NUM_AXES];
    logic [POSITION_BITS-1:0] lane_pos [NUM_AXES];
    logic [31:0]          pos32     [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_max_steps[a] <= MOVE_BITS'(32767);
            end
            r_pos_dir  <= 3'b111;
            r_home_dir <= 3'b000;
            r_homed    <= 3'b000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_X:    r_max_steps[0] <= i_cfg_data;
                CFG_MAX_Y:    r_max_steps[1] <= i_cfg_data;
                CFG_MAX_Z:    r_max_steps[2] <= i_cfg_data;
                CFG_POS_DIR:  r_pos_dir      <= i_cfg_data[2:0];
                CFG_HOME_DIR: r_home_dir     <= i_cfg_data[2:0];
                CFG_HOMED:    r_homed        <= i_cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    assign move[0] = i_move_x;
    assign move[1] = i_move_y;
    assign move[2] = i_move_z;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        tadda_lane #(
            .MOVE_BITS     (MOVE_BITS),
            .POSITION_BITS (POSITION_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl),
            .i_move      (move[a]),
            .i_max_steps (r_max_steps[a]),
            .i_pos_dir   (r_pos_dir[a]),
            .i_home_dir  (r_home_dir[a]),
            .i_homed     (r_homed[a]),
            .i_major     (major),
            .o_stat      (lane_stat[a]),
            .o_load_mag  (load_mag[a]),
            .o_pos       (lane_pos[a])
        );

        assign o_dir_level[a] = lane_stat[a].dir;

        if (POSITION_BITS >= 32) begin : g_pos_trunc
            assign pos32[a] = lane_pos[a][31:0];
        end else begin : g_pos_ext
            assign pos32[a] = {{(32-POSITION_BITS){1'b0}}, lane_pos[a]};
        end
    end

    tadda_merge #(
        .MOVE_BITS (MOVE_BITS)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_limit_before (i_limit_before),
        .i_limit_after  (i_limit_after),
        .i_stat         (lane_stat),
        .i_load_mag     (load_mag),
        .o_ctl          (lane_ctl),
        .o_major        (major),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_step_mask    (o_step_mask),
        .o_move_done    (o_move_done),
        .o_move_fault   (o_move_fault),
        .o_busy_res     (o_busy_res)
    );

    assign o_pos_x = signed'(pos32[0]);
    assign o_pos_y = signed'(pos32[1]);
    assign o_pos_z = signed'(pos32[2]);

endmodule
